[rtl/core/rtmu_pkg.sv]
// shared types and codes for the exact-match routing table
// operation and status codes, control word carried along the cell chain
// no dependencies
`default_nettype none

package rtmu_pkg;

    localparam int INDEX_BITS = 4;
    localparam int COUNT_BITS = 5;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_READ   = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        STS_ADDED     = 3'd0,
        STS_UPDATED   = 3'd1,
        STS_DUPLICATE = 3'd2,
        STS_FULL      = 3'd3,
        STS_FOUND     = 3'd4,
        STS_MISS      = 3'd5
    } status_t;

    // request control travelling with each transaction
    typedef struct packed {
        op_t     op;
        logic    done;
        status_t status;
    } ctl_t;

endpackage

`default_nettype wire

[rtl/core/rtmu_cell.sv]
// one table slot of the routing table chain: holds one entry and its valid bit
// acts on a passing request and hands it to the next slot
// depends on rtmu_pkg
`default_nettype none

module rtmu_cell
    import rtmu_pkg::*;
#(
    parameter int POS       = 0,
    parameter int NODE_BITS = 8,
    parameter int COST_BITS = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire ctl_t                  in_ctl,
    input  wire logic [NODE_BITS-1:0]  in_dest,
    input  wire logic [NODE_BITS-1:0]  in_hop,
    input  wire logic [COST_BITS-1:0]  in_cost,
    input  wire logic [INDEX_BITS-1:0] in_index,
    input  wire logic [NODE_BITS-1:0]  in_rdest,
    input  wire logic [NODE_BITS-1:0]  in_rhop,
    input  wire logic [COST_BITS-1:0]  in_rcost,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output ctl_t                       out_ctl,
    output logic [NODE_BITS-1:0]       out_dest,
    output logic [NODE_BITS-1:0]       out_hop,
    output logic [COST_BITS-1:0]       out_cost,
    output logic [INDEX_BITS-1:0]      out_index,
    output logic [NODE_BITS-1:0]       out_rdest,
    output logic [NODE_BITS-1:0]       out_rhop,
    output logic [COST_BITS-1:0]       out_rcost
);

    logic                 vld_reg;
    logic [NODE_BITS-1:0] dest_reg;
    logic [NODE_BITS-1:0] hop_reg;
    logic [COST_BITS-1:0] cost_reg;

    logic                 valid_reg;
    ctl_t                 ctl_reg;
    logic [NODE_BITS-1:0] dest_q_reg;
    logic [NODE_BITS-1:0] hop_q_reg;
    logic [COST_BITS-1:0] cost_q_reg;
    logic [INDEX_BITS-1:0] index_reg;
    logic [NODE_BITS-1:0] rdest_reg;
    logic [NODE_BITS-1:0] rhop_reg;
    logic [COST_BITS-1:0] rcost_reg;

    logic                 take;
    logic                 hit;
    logic                 at_index;
    logic                 wr_new;
    logic                 wr_upd;
    ctl_t                 ctl_next;
    logic [NODE_BITS-1:0] rdest_next;
    logic [NODE_BITS-1:0] rhop_next;
    logic [COST_BITS-1:0] rcost_next;

    assign in_ready = !valid_reg || out_ready;
    assign take     = in_valid && in_ready;
    assign hit      = vld_reg && (dest_reg == in_dest);
    assign at_index = vld_reg && (32'(in_index) == POS);

    always_comb
    begin
        ctl_next   = in_ctl;
        rdest_next = in_rdest;
        rhop_next  = in_rhop;
        rcost_next = in_rcost;
        wr_new     = 1'b0;
        wr_upd     = 1'b0;
        if (!in_ctl.done)
        begin
            case (in_ctl.op)
                OP_ADD:
                begin
                    if (hit)
                    begin
                        ctl_next.done = 1'b1;
                        if (hop_reg == in_hop && cost_reg == in_cost)
                        begin
                            ctl_next.status = STS_DUPLICATE;
                        end
                        else
                        begin
                            ctl_next.status = STS_UPDATED;
                            wr_upd          = 1'b1;
                        end
                    end
                    else if (!vld_reg)
                    begin
                        // first free slot: valid slots always form a prefix
                        ctl_next.done   = 1'b1;
                        ctl_next.status = STS_ADDED;
                        wr_new          = 1'b1;
                    end
                end
                OP_LOOKUP:
                begin
                    if (hit)
                    begin
                        ctl_next.done   = 1'b1;
                        ctl_next.status = STS_FOUND;
                        rdest_next      = dest_reg;
                        rhop_next       = hop_reg;
                        rcost_next      = cost_reg;
                    end
                end
                OP_READ:
                begin
                    if (at_index)
                    begin
                        ctl_next.done   = 1'b1;
                        ctl_next.status = STS_FOUND;
                        rdest_next      = dest_reg;
                        rhop_next       = hop_reg;
                        rcost_next      = cost_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (take && wr_new)
            begin
                vld_reg <= 1'b1;
            end
            if (in_ready)
            begin
                valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && wr_new)
        begin
            dest_reg <= in_dest;
        end
        if (take && (wr_new || wr_upd))
        begin
            hop_reg  <= in_hop;
            cost_reg <= in_cost;
        end
        if (take)
        begin
            ctl_reg    <= ctl_next;
            dest_q_reg <= in_dest;
            hop_q_reg  <= in_hop;
            cost_q_reg <= in_cost;
            index_reg  <= in_index;
            rdest_reg  <= rdest_next;
            rhop_reg   <= rhop_next;
            rcost_reg  <= rcost_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctl   = ctl_reg;
    assign out_dest  = dest_q_reg;
    assign out_hop   = hop_q_reg;
    assign out_cost  = cost_q_reg;
    assign out_index = index_reg;
    assign out_rdest = rdest_reg;
    assign out_rhop  = rhop_reg;
    assign out_rcost = rcost_reg;

endmodule

`default_nettype wire

[rtl/core/rtmu_tail.sv]
// end of the routing table chain: final status, entry count and result register
// depends on rtmu_pkg
`default_nettype none

module rtmu_tail
    import rtmu_pkg::*;
#(
    parameter int NODE_BITS = 8,
    parameter int COST_BITS = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire ctl_t                 in_ctl,
    input  wire logic [NODE_BITS-1:0] in_rdest,
    input  wire logic [NODE_BITS-1:0] in_rhop,
    input  wire logic [COST_BITS-1:0] in_rcost,
    output logic                      res_valid,
    input  wire logic                 res_ready,
    output status_t                   res_status,
    output logic [NODE_BITS-1:0]      res_dest,
    output logic [NODE_BITS-1:0]      res_hop,
    output logic [COST_BITS-1:0]      res_cost,
    output logic [COUNT_BITS-1:0]     res_count
);

    logic                  valid_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    status_t               status_reg;
    status_t               status_next;
    logic [NODE_BITS-1:0]  dest_reg;
    logic [NODE_BITS-1:0]  hop_reg;
    logic [COST_BITS-1:0]  cost_reg;
    logic [COUNT_BITS-1:0] cnt_out_reg;
    logic                  take;

    assign in_ready = !valid_reg || res_ready;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        if (in_ctl.done)
        begin
            status_next = in_ctl.status;
        end
        else if (in_ctl.op == OP_ADD)
        begin
            // walked every slot, no match and no free slot
            status_next = STS_FULL;
        end
        else
        begin
            status_next = STS_MISS;
        end
        count_next = (status_next == STS_ADDED) ? count_reg + 1'b1 : count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                valid_reg <= in_valid;
            end
            if (take)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            status_reg  <= status_next;
            dest_reg    <= in_rdest;
            hop_reg     <= in_rhop;
            cost_reg    <= in_rcost;
            cnt_out_reg <= count_next;
        end
    end

    assign res_valid  = valid_reg;
    assign res_status = status_reg;
    assign res_dest   = dest_reg;
    assign res_hop    = hop_reg;
    assign res_cost   = cost_reg;
    assign res_count  = cnt_out_reg;

endmodule

`default_nettype wire

[rtl/core/routing_table_match_update.sv]
// Exact-match routing table built as a chain of ENTRIES slot cells and a result stage.
// Every transaction walks the chain one slot per cycle unless stalled, registered in each
// slot cell and then in the result stage; the chain is fully pipelined and accepts one
// transaction per cycle as long as results are taken, with each slot stage and the
// result stage holding one transaction in flight. Because every slot sees transactions
// in arrival order, later transactions always see the table as left by earlier ones.
// Table contents are not cleared at reset; only the slot valid bits, the pipeline valid
// flags and the entry count are.
// depends on rtmu_pkg, rtmu_cell, rtmu_tail
`default_nettype none

module routing_table_match_update
    import rtmu_pkg::*;
#(
    parameter int ENTRIES   = 16,
    parameter int NODE_BITS = 8,
    parameter int COST_BITS = 16,
    localparam int IN_BITS  = 2 * NODE_BITS + COST_BITS + INDEX_BITS,
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_BITS = 2 * NODE_BITS + COST_BITS + COUNT_BITS,
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    // destination, next_hop, cost, index, zero fill
    input  wire logic [IN_W-1:0]  s_tdata,
    // operation
    input  wire logic [1:0]       s_tuser,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    // out_destination, out_next_hop, out_cost, entry_count, zero fill
    output logic [OUT_W-1:0]      m_tdata,
    // status
    output logic [2:0]            m_tuser
);

    logic                  vld   [ENTRIES+1];
    logic                  rdy   [ENTRIES+1];
    ctl_t                  ctl   [ENTRIES+1];
    logic [NODE_BITS-1:0]  dest  [ENTRIES+1];
    logic [NODE_BITS-1:0]  hop   [ENTRIES+1];
    logic [COST_BITS-1:0]  cost  [ENTRIES+1];
    logic [INDEX_BITS-1:0] idx   [ENTRIES+1];
    logic [NODE_BITS-1:0]  rdest [ENTRIES+1];
    logic [NODE_BITS-1:0]  rhop  [ENTRIES+1];
    logic [COST_BITS-1:0]  rcost [ENTRIES+1];

    status_t               res_status;
    logic [NODE_BITS-1:0]  res_dest;
    logic [NODE_BITS-1:0]  res_hop;
    logic [COST_BITS-1:0]  res_cost;
    logic [COUNT_BITS-1:0] res_count;

    // request entering the first slot
    assign vld[0]        = s_tvalid;
    assign s_tready      = rdy[0];
    assign ctl[0].op     = op_t'(s_tuser);
    assign ctl[0].done   = 1'b0;
    assign ctl[0].status = STS_MISS;
    assign dest[0]       = s_tdata[NODE_BITS-1:0];
    assign hop[0]        = s_tdata[2*NODE_BITS-1:NODE_BITS];
    assign cost[0]       = s_tdata[2*NODE_BITS+COST_BITS-1:2*NODE_BITS];
    assign idx[0]        = s_tdata[IN_BITS-1:2*NODE_BITS+COST_BITS];
    assign rdest[0]      = '0;
    assign rhop[0]       = '0;
    assign rcost[0]      = '0;

    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_slot
        rtmu_cell #(
            .POS       (g),
            .NODE_BITS (NODE_BITS),
            .COST_BITS (COST_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (vld[g]),
            .in_ready  (rdy[g]),
            .in_ctl    (ctl[g]),
            .in_dest   (dest[g]),
            .in_hop    (hop[g]),
            .in_cost   (cost[g]),
            .in_index  (idx[g]),
            .in_rdest  (rdest[g]),
            .in_rhop   (rhop[g]),
            .in_rcost  (rcost[g]),
            .out_valid (vld[g+1]),
            .out_ready (rdy[g+1]),
            .out_ctl   (ctl[g+1]),
            .out_dest  (dest[g+1]),
            .out_hop   (hop[g+1]),
            .out_cost  (cost[g+1]),
            .out_index (idx[g+1]),
            .out_rdest (rdest[g+1]),
            .out_rhop  (rhop[g+1]),
            .out_rcost (rcost[g+1])
        );
    end

    rtmu_tail #(
        .NODE_BITS (NODE_BITS),
        .COST_BITS (COST_BITS)
    ) u_tail (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (vld[ENTRIES]),
        .in_ready   (rdy[ENTRIES]),
        .in_ctl     (ctl[ENTRIES]),
        .in_rdest   (rdest[ENTRIES]),
        .in_rhop    (rhop[ENTRIES]),
        .in_rcost   (rcost[ENTRIES]),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .res_status (res_status),
        .res_dest   (res_dest),
        .res_hop    (res_hop),
        .res_cost   (res_cost),
        .res_count  (res_count)
    );

    // the last slot's request fields other than the result are not needed further
    logic unused_tail;
    assign unused_tail = ^{dest[ENTRIES], hop[ENTRIES], cost[ENTRIES], idx[ENTRIES]};

    assign m_tuser = res_status;
    assign m_tdata = OUT_W'({res_count, res_cost, res_hop, res_dest});

endmodule

`default_nettype wire

[rtl/core/rtmu_checker.sv]
// port-level checks for the routing table, bound to routing_table_match_update
// depends on rtmu_pkg and the top level's port list
`default_nettype none

module rtmu_checker
    import rtmu_pkg::*;
#(
    parameter int ENTRIES   = 16,
    parameter int NODE_BITS = 8,
    parameter int COST_BITS = 16,
    localparam int OUT_BITS = 2 * NODE_BITS + COST_BITS + COUNT_BITS,
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8,
    localparam int FULL_CNT = ENTRIES % 32
) (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             m_tvalid,
    input wire logic             m_tready,
    input wire logic [OUT_W-1:0] m_tdata,
    input wire logic [2:0]       m_tuser
);

    localparam int PAY_BITS = 2 * NODE_BITS + COST_BITS;

    logic [PAY_BITS-1:0]   payload;
    logic [COUNT_BITS-1:0] count;

    assign payload = m_tdata[PAY_BITS-1:0];
    assign count   = m_tdata[OUT_BITS-1:PAY_BITS];

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // only a hit carries entry data
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != STS_FOUND |-> payload == '0)
        else $error("entry data on a non-hit result");

    // a refused add only happens with every slot in use
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == STS_FULL |-> count == COUNT_BITS'(FULL_CNT))
        else $error("table full reported with free slots");

    // a fresh add leaves at least one entry, as long as the count cannot wrap
    a_added: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == STS_ADDED && ENTRIES < 32 |-> count != '0)
        else $error("add reported with empty table");

    // no result straight out of reset
    a_reset: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind routing_table_match_update rtmu_checker #(
    .ENTRIES   (ENTRIES),
    .NODE_BITS (NODE_BITS),
    .COST_BITS (COST_BITS)
) u_rtmu_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

[dv/tb.sv]
// testbench for routing_table_match_update: directed rows, then random add, lookup, read and
// undefined-op transactions, scored against listed results or a model, random stalls on both sides
// depends on rtmu_pkg and the routing_table_match_update rtl
module tb;
    import rtmu_pkg::*;

    localparam int TABLE_SLOTS  = 16;
    localparam int TOTAL_ITEMS  = 1850;
    localparam int CALM_ITEMS   = 200;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int REPORT_MAX   = 10;
    // operation code the block does not define
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  dst;
        logic [7:0]  hop;
        logic [15:0] cost;
        logic [3:0]  idx;
    } route_req_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  dst;
        logic [7:0]  hop;
        logic [15:0] cost;
        logic [4:0]  entries;
    } route_res_t;

    typedef struct packed {
        route_req_t req;
        bit         typed;
        route_res_t res;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [2:0]  m_tuser;

    // model of the table contents
    logic [7:0]  tbl_dst [TABLE_SLOTS];
    logic [7:0]  tbl_hop [TABLE_SLOTS];
    logic [15:0] tbl_cost [TABLE_SLOTS];
    int          tbl_used = 0;

    route_res_t  pending_results [$];
    dir_row_t    dir_rows [$];
    int          mismatches = 0;
    int          results_seen = 0;
    int          sent_count = 0;
    int          cycles = 0;
    int          status_hist [8];
    bit          calm = 1'b0;

    routing_table_match_update DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #4 clk = ~clk;

    function automatic route_req_t req_of(logic [1:0] op, logic [7:0] dst, logic [7:0] hop,
                                          logic [15:0] cost, logic [3:0] idx);
        route_req_t r;
        r.op   = op;
        r.dst  = dst;
        r.hop  = hop;
        r.cost = cost;
        r.idx  = idx;
        return r;
    endfunction

    function automatic route_res_t res_of(status_t status, logic [7:0] dst, logic [7:0] hop,
                                          logic [15:0] cost, logic [4:0] entries);
        route_res_t e;
        e.status  = status;
        e.dst     = dst;
        e.hop     = hop;
        e.cost    = cost;
        e.entries = entries;
        return e;
    endfunction

    function automatic int table_find(logic [7:0] dst);
        for (int i = 0; i < tbl_used; i++)
        begin
            if (tbl_dst[i] == dst)
                return i;
        end
        return -1;
    endfunction

    // applies one transaction to the table model and returns the result it should produce
    function automatic route_res_t table_apply(route_req_t r);
        route_res_t e;
        int pos;
        e = '0;
        e.status = STS_MISS;
        case (r.op)
            OP_ADD:
            begin
                pos = table_find(r.dst);
                if (pos >= 0)
                begin
                    if (tbl_hop[pos] == r.hop && tbl_cost[pos] == r.cost)
                        e.status = STS_DUPLICATE;
                    else
                    begin
                        tbl_hop[pos]  = r.hop;
                        tbl_cost[pos] = r.cost;
                        e.status = STS_UPDATED;
                    end
                end
                else if (tbl_used >= TABLE_SLOTS)
                    e.status = STS_FULL;
                else
                begin
                    tbl_dst[tbl_used]  = r.dst;
                    tbl_hop[tbl_used]  = r.hop;
                    tbl_cost[tbl_used] = r.cost;
                    tbl_used++;
                    e.status = STS_ADDED;
                end
            end
            OP_LOOKUP:
            begin
                pos = table_find(r.dst);
                if (pos >= 0)
                    e = res_of(STS_FOUND, tbl_dst[pos], tbl_hop[pos], tbl_cost[pos], '0);
            end
            OP_READ:
            begin
                if (int'(r.idx) < tbl_used)
                    e = res_of(STS_FOUND, tbl_dst[r.idx], tbl_hop[r.idx], tbl_cost[r.idx], '0);
            end
            default: ;
        endcase
        e.entries = 5'(tbl_used);
        return e;
    endfunction

    // mostly well-formed traffic aimed at stored destinations, plus noise
    function automatic route_req_t random_req();
        route_req_t r;
        int pick;
        int slot;
        r = req_of(OP_ADD, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   16'($urandom_range(0, 65535)), 4'($urandom_range(0, 15)));
        pick = $urandom_range(0, 99);
        slot = (tbl_used > 0) ? $urandom_range(0, tbl_used - 1) : 0;
        if (pick < 35)
        begin
            r.op = OP_LOOKUP;
            if (tbl_used > 0 && $urandom_range(0, 9) < 7)
                r.dst = tbl_dst[slot];
        end
        else if (pick < 60)
            r.op = OP_READ;
        else if (pick < 90)
        begin
            r.op = OP_ADD;
            case ($urandom_range(0, 2))
                0:
                begin
                    if (tbl_used > 0)
                        r.dst = tbl_dst[slot];
                end
                1:
                begin
                    // exact copy of a stored entry
                    if (tbl_used > 0)
                    begin
                        r.dst  = tbl_dst[slot];
                        r.hop  = tbl_hop[slot];
                        r.cost = tbl_cost[slot];
                    end
                end
                default: ;
            endcase
        end
        else
            r.op = OP_UNUSED;
        return r;
    endfunction

    task automatic add_row(input route_req_t r, input bit typed, input route_res_t e);
        dir_row_t row;
        row.req   = r;
        row.typed = typed;
        row.res   = e;
        dir_rows.push_back(row);
    endtask

    task automatic send_req(input route_req_t r, input bit typed, input route_res_t e);
        route_res_t pred;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.op;
        s_tdata  <= {4'b0, r.idx, r.cost, r.hop, r.dst};
        do
            @(posedge clk);
        while (!s_tready);
        pred = table_apply(r);
        pending_results.push_back(typed ? e : pred);
        sent_count++;
        if (sent_count >= TOTAL_ITEMS - CALM_ITEMS)
            calm = 1'b1;
    endtask

    task automatic check_result(input route_res_t got);
        route_res_t want;
        results_seen++;
        status_hist[got.status]++;
        if (pending_results.size() == 0)
        begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("unexpected result %0d: status %0d dst %h hop %h cost %h count %0d",
                         results_seen, got.status, got.dst, got.hop, got.cost, got.entries);
            return;
        end
        want = pending_results.pop_front();
        if (got.status != want.status || got.dst != want.dst || got.hop != want.hop ||
            got.cost != want.cost || got.entries != want.entries)
        begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
            begin
                $display("result %0d expected: status %0d dst %h hop %h cost %h count %0d",
                         results_seen, want.status, want.dst, want.hop, want.cost, want.entries);
                $display("result %0d actual:   status %0d dst %h hop %h cost %h count %0d",
                         results_seen, got.status, got.dst, got.hop, got.cost, got.entries);
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            check_result(res_of(status_t'(m_tuser), m_tdata[7:0], m_tdata[15:8],
                                m_tdata[31:16], m_tdata[36:32]));
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     pending_results.size());
            $display("Mismatches found");
            $finish;
        end
    end

    // result side back-pressure
    initial
    begin
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    initial
    begin
        for (int s = 0; s < 8; s++)
            status_hist[s] = 0;

        // empty table, then one entry walked through duplicate and rewrite
        add_row(req_of(OP_LOOKUP, 8'h00, 8'h00, 16'h0000, 4'h0), 1'b1,
                res_of(STS_MISS, 8'h00, 8'h00, 16'h0000, 5'd0));
        add_row(req_of(OP_READ, 8'h00, 8'h00, 16'h0000, 4'hf), 1'b1,
                res_of(STS_MISS, 8'h00, 8'h00, 16'h0000, 5'd0));
        add_row(req_of(OP_UNUSED, 8'hff, 8'hff, 16'hffff, 4'hf), 1'b1,
                res_of(STS_MISS, 8'h00, 8'h00, 16'h0000, 5'd0));
        add_row(req_of(OP_ADD, 8'h00, 8'h00, 16'h0000, 4'h0), 1'b1,
                res_of(STS_ADDED, 8'h00, 8'h00, 16'h0000, 5'd1));
        add_row(req_of(OP_ADD, 8'h00, 8'h00, 16'h0000, 4'h0), 1'b1,
                res_of(STS_DUPLICATE, 8'h00, 8'h00, 16'h0000, 5'd1));
        add_row(req_of(OP_ADD, 8'h00, 8'hff, 16'hffff, 4'h0), 1'b1,
                res_of(STS_UPDATED, 8'h00, 8'h00, 16'h0000, 5'd1));
        add_row(req_of(OP_LOOKUP, 8'h00, 8'h00, 16'h0000, 4'h0), 1'b1,
                res_of(STS_FOUND, 8'h00, 8'hff, 16'hffff, 5'd1));
        add_row(req_of(OP_READ, 8'h00, 8'h00, 16'h0000, 4'h0), 1'b1,
                res_of(STS_FOUND, 8'h00, 8'hff, 16'hffff, 5'd1));
        add_row(req_of(OP_READ, 8'h00, 8'h00, 16'h0000, 4'h1), 1'b1,
                res_of(STS_MISS, 8'h00, 8'h00, 16'h0000, 5'd1));
        add_row(req_of(OP_ADD, 8'hff, 8'h00, 16'h0000, 4'h0), 1'b1,
                res_of(STS_ADDED, 8'h00, 8'h00, 16'h0000, 5'd2));
        // fill the remaining slots
        for (int k = 1; k <= 14; k++)
            add_row(req_of(OP_ADD, 8'(k * 17), 8'(k), 16'(k * 4099), 4'(k)), 1'b0, '0);
        // full table: new destination refused, existing one still rewritable
        add_row(req_of(OP_ADD, 8'h80, 8'h01, 16'h0001, 4'h0), 1'b1,
                res_of(STS_FULL, 8'h00, 8'h00, 16'h0000, 5'd16));
        add_row(req_of(OP_ADD, 8'hff, 8'h12, 16'h3456, 4'h0), 1'b1,
                res_of(STS_UPDATED, 8'h00, 8'h00, 16'h0000, 5'd16));
        add_row(req_of(OP_READ, 8'h00, 8'h00, 16'h0000, 4'hf), 1'b0, '0);
        add_row(req_of(OP_LOOKUP, 8'h80, 8'h00, 16'h0000, 4'h0), 1'b1,
                res_of(STS_MISS, 8'h00, 8'h00, 16'h0000, 5'd16));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);
        while (sent_count < TOTAL_ITEMS)
            send_req(random_req(), 1'b0, '0);
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d transactions sent, %0d results checked, table holding %0d entries",
                 sent_count, results_seen, tbl_used);
        $display("added %0d, updated %0d, duplicate %0d, full %0d, found %0d, miss %0d",
                 status_hist[STS_ADDED], status_hist[STS_UPDATED],
                 status_hist[STS_DUPLICATE], status_hist[STS_FULL],
                 status_hist[STS_FOUND], status_hist[STS_MISS]);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[sim.f]
rtl/core/rtmu_pkg.sv
rtl/core/rtmu_cell.sv
rtl/core/rtmu_tail.sv
rtl/core/routing_table_match_update.sv
rtl/core/rtmu_checker.sv
dv/tb.sv
